>>> src/mwcrc_pkg.sv
package mwcrc_pkg;

   localparam int unsigned MAX_BYTES = 65535;
   localparam int unsigned POS_W = 16;

   localparam logic [31:0] POLY_8  = 32'h0000_001D;
   localparam logic [31:0] POLY_16 = 32'h0000_1021;
   localparam logic [31:0] POLY_32 = 32'h04C1_1DB7;
   localparam logic [31:0] MASK_8  = 32'h0000_00FF;
   localparam logic [31:0] MASK_16 = 32'h0000_FFFF;
   localparam logic [31:0] MASK_32 = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_CRC8  = 2'd0,
      KIND_CRC16 = 2'd1,
      KIND_CRC32 = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_WINDOW = 2'd1,
      STATUS_KIND   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_KIND   = 2'd0,
      REG_OFFSET = 2'd1,
      REG_LENGTH = 2'd2
   } reg_addr_type;

   typedef struct packed {
      kind_type           kind;
      logic [POS_W-1:0]   offset;
      logic [POS_W-1:0]   length;
   } cfg_type;

   typedef struct packed {
      logic [31:0] crc;
      status_type  status;
   } result_type;

   // msb-first byte update, width picked by kind
   function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                            input kind_type kind,
                                            input logic [7:0] data);
      logic [31:0] crc;
      logic [31:0] mask;
      logic [31:0] poly;
      logic [31:0] top;
      logic [4:0]  lift;
      mask = MASK_32;
      poly = POLY_32;
      top  = 32'h8000_0000;
      lift = 5'd24;
      case (kind)
         KIND_CRC8: begin
            mask = MASK_8;
            poly = POLY_8;
            top  = 32'h0000_0080;
            lift = 5'd0;
         end
         KIND_CRC16: begin
            mask = MASK_16;
            poly = POLY_16;
            top  = 32'h0000_8000;
            lift = 5'd8;
         end
         default: begin
            mask = MASK_32;
            poly = POLY_32;
            top  = 32'h8000_0000;
            lift = 5'd24;
         end
      endcase
      crc = (crc_in & mask) ^ ({24'd0, data} << lift);
      for (int i = 0; i < 8; i++) begin
         if ((crc & top) != 32'd0) begin
            crc = ((crc << 1) ^ poly) & mask;
         end else begin
            crc = (crc << 1) & mask;
         end
      end
      return crc;
   endfunction

   function automatic logic [31:0] kind_mask(input kind_type kind);
      logic [31:0] m;
      case (kind)
         KIND_CRC8:  m = MASK_8;
         KIND_CRC16: m = MASK_16;
         KIND_CRC32: m = MASK_32;
         default:    m = 32'd0;
      endcase
      return m;
   endfunction

endpackage

>>> src/mwcrc_update.sv
module mwcrc_update
   import mwcrc_pkg::*;
(
   input  cfg_type           cfg,
   input  logic [31:0]       acc,
   input  logic [POS_W-1:0]  pos,
   input  logic [7:0]        data_byte,
   output logic [31:0]       acc_next,
   output logic [POS_W-1:0]  pos_next,
   output result_type        result
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BYTES);

   logic [POS_W:0] win_end;
   logic [POS_W:0] count;
   logic           in_window;
   logic           at_max;

   assign win_end   = {1'b0, cfg.offset} + {1'b0, cfg.length};
   assign in_window = (pos >= cfg.offset) && ({1'b0, pos} < win_end);
   assign at_max    = (pos >= MAX_POS);
   assign count     = at_max ? {1'b0, MAX_POS} : ({1'b0, pos} + 1'b1);
   assign pos_next  = at_max ? pos : count[POS_W-1:0];

   always_comb begin
      if (in_window && (cfg.kind != KIND_NONE)) begin
         acc_next = crc_feed(acc, cfg.kind, data_byte);
      end else begin
         acc_next = acc;
      end
   end

   always_comb begin
      if (win_end > count) begin
         result.crc    = 32'd0;
         result.status = STATUS_WINDOW;
      end else if (cfg.kind == KIND_NONE) begin
         result.crc    = 32'd0;
         result.status = STATUS_KIND;
      end else begin
         result.crc    = acc_next & kind_mask(cfg.kind);
         result.status = STATUS_OK;
      end
   end

endmodule

>>> src/multi_width_crc_window_engine.sv
// a byte accepted into the input register is processed when that stage advances, and the
// result of a last byte is then registered into the output register that drives rsp_tdata
// throughput: one byte per cycle through the combinational crc accumulator update; a
// last byte holds the input only while the previous result still waits for the receiver
// reset: synchronous, active high; clears the valid flags of both stages, the byte position, the
// accumulator (to all ones) and the configuration registers
module multi_width_crc_window_engine
   import mwcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic [31:0]      acc_ff;
   logic [31:0]      acc_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   result_type       out_ff;
   logic [31:0]      acc_next;
   logic [POS_W-1:0] pos_next;
   result_type       result;
   logic             advance;
   logic             req_fire;
   logic             csr_write;
   reg_addr_type     csr_reg;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_addr_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_KIND:   cfg_in.kind   = kind_type'(csr_pwdata[1:0]);
            REG_OFFSET: cfg_in.offset = csr_pwdata[POS_W-1:0];
            REG_LENGTH: cfg_in.length = csr_pwdata[POS_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_KIND:   csr_prdata = {30'd0, cfg_ff.kind};
         REG_OFFSET: csr_prdata = {{(32-POS_W){1'b0}}, cfg_ff.offset};
         REG_LENGTH: csr_prdata = {{(32-POS_W){1'b0}}, cfg_ff.length};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind   <= KIND_CRC8;
         cfg_ff.offset <= '0;
         cfg_ff.length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input stage moves on unless a last word would overwrite a waiting result
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   mwcrc_update u_update (
      .cfg       (cfg_ff),
      .acc       (acc_ff),
      .pos       (pos_ff),
      .data_byte (in_byte_ff),
      .acc_next  (acc_next),
      .pos_next  (pos_next),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      pos_in = pos_ff;
      if (advance) begin
         if (in_last_ff) begin
            acc_in = CRC_INIT;
            pos_in = '0;
         end else begin
            acc_in = acc_next;
            pos_in = pos_next;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= CRC_INIT;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.crc;
   assign rsp_tuser  = out_ff.status;

endmodule

>>> dv/tb_multi_width_crc_window_engine.sv
`timescale 1ns / 1ps

module tb_multi_width_crc_window_engine;
   import mwcrc_pkg::*;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_DIGITS,
      FILL_ZERO,
      FILL_ONES
   } fill_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_CHOPPY,
      RX_SPARSE
   } rx_mode_type;

   typedef struct {
      bit          do_cfg;
      kind_type    kind;
      logic [15:0] offset;
      logic [15:0] length;
      int unsigned nbytes;
      fill_type    fill;
      bit          ends;
      bit          typed;
      status_type  status;
      logic [31:0] crc;
   } dir_row_type;

   localparam int unsigned DIR_ROWS = 19;
   localparam int unsigned RANDOM_BYTES = 500;
   localparam int unsigned PRESSURE_MSGS = 30;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] crc_value
   logic [1:0]  rsp_tuser;          // [1:0] status
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   multi_width_crc_window_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the block's registers and running crc state
   cfg_type     shadow_cfg;
   logic [31:0] run_acc;
   int unsigned run_pos;

   result_type  crc_expected[$];
   result_type  want;
   dir_row_type dir_rows [0:DIR_ROWS-1];

   int unsigned errors = 0;
   int unsigned results_checked = 0;
   int unsigned bytes_sent = 0;
   int unsigned msgs_sent = 0;
   int unsigned cfg_writes = 0;
   int unsigned burst_left = 0;
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   bit          hold_request = 1'b0;
   rx_mode_type rx_mode = RX_STEADY;

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   function automatic logic [31:0] width_mask(input kind_type k);
      case (k)
         KIND_CRC8:  return 32'h0000_00FF;
         KIND_CRC16: return 32'h0000_FFFF;
         default:    return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [31:0] crc_byte_update(input logic [31:0] acc, input kind_type k,
                                                   input logic [7:0] b);
      int unsigned w;
      logic [31:0] poly;
      logic [31:0] mask;
      logic [31:0] r;
      case (k)
         KIND_CRC8: begin
            w = 8;
            poly = POLY_8;
         end
         KIND_CRC16: begin
            w = 16;
            poly = POLY_16;
         end
         default: begin
            w = 32;
            poly = POLY_32;
         end
      endcase
      mask = width_mask(k);
      r = (acc & mask) ^ (32'(b) << (w - 8));
      repeat (8) begin
         if (r[w-1]) begin
            r = ((r << 1) ^ poly) & mask;
         end else begin
            r = (r << 1) & mask;
         end
      end
      return r;
   endfunction

   // advances the shadow state by one byte; returns 1 when the byte closes a message
   function automatic bit crc_window_predict(input logic [7:0] b, input bit last,
                                             output result_type res);
      int unsigned win_end;
      int unsigned count;
      win_end = 32'(shadow_cfg.offset) + 32'(shadow_cfg.length);
      res = '{crc: 32'd0, status: STATUS_OK};
      if (shadow_cfg.kind != KIND_NONE && run_pos >= 32'(shadow_cfg.offset) &&
          run_pos < win_end) begin
         run_acc = crc_byte_update(run_acc, shadow_cfg.kind, b);
      end
      count = (run_pos < MAX_BYTES) ? run_pos + 1 : MAX_BYTES;
      if (run_pos < MAX_BYTES) begin
         run_pos++;
      end
      if (!last) begin
         return 1'b0;
      end
      if (win_end > count) begin
         res = '{crc: 32'd0, status: STATUS_WINDOW};
      end else if (shadow_cfg.kind == KIND_NONE) begin
         res = '{crc: 32'd0, status: STATUS_KIND};
      end else begin
         res = '{crc: run_acc & width_mask(shadow_cfg.kind), status: STATUS_OK};
      end
      run_acc = CRC_INIT;
      run_pos = 0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] fill_byte(input fill_type f, input int unsigned i);
      case (f)
         FILL_DIGITS: return 8'h31 + 8'(i % 9);
         FILL_ZERO:   return 8'h00;
         FILL_ONES:   return 8'hFF;
         default:     return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit last, input bit typed,
                            input result_type typed_res);
      result_type res;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (crc_window_predict(b, last, res)) begin
         crc_expected.push_back(typed ? typed_res : res);
         msgs_sent++;
      end
   endtask

   // registers move only once every pending word is out and the pipe has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (crc_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_addr_type r, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cfg_writes++;
      case (r)
         REG_KIND:   shadow_cfg.kind = kind_type'(v[1:0]);
         REG_OFFSET: shadow_cfg.offset = v[15:0];
         default:    shadow_cfg.length = v[15:0];
      endcase
   endtask

   task automatic set_cfg(input kind_type k, input logic [15:0] off, input logic [15:0] len);
      wait_idle();
      write_reg(REG_KIND, 32'(k));
      write_reg(REG_OFFSET, 32'(off));
      write_reg(REG_LENGTH, 32'(len));
   endtask

   task automatic run_row(input dir_row_type row);
      result_type typed_res;
      typed_res = '{crc: row.crc, status: row.status};
      if (row.do_cfg) begin
         set_cfg(row.kind, row.offset, row.length);
      end
      for (int unsigned i = 0; i < row.nbytes; i++) begin
         send_byte(fill_byte(row.fill, i), row.ends && (i == row.nbytes - 1), row.typed,
                   typed_res);
      end
   endtask

   function automatic kind_type random_kind();
      if ($urandom_range(0, 7) == 0) begin
         return KIND_NONE;
      end
      return kind_type'($urandom_range(0, 2));
   endfunction

   task automatic random_cfg(input int unsigned len);
      int unsigned off;
      int unsigned wlen;
      int unsigned pick;
      pick = $urandom_range(0, 15);
      off = $urandom_range(0, len);
      if (pick == 0) begin
         // full-range window, nearly always beyond the message
         off = $urandom_range(0, 65535);
         wlen = $urandom_range(0, 65535);
      end else if (pick < 3) begin
         wlen = len - off + $urandom_range(1, 3);
      end else begin
         wlen = $urandom_range(0, len - off);
      end
      set_cfg(random_kind(), 16'(off), 16'(wlen));
   endtask

   task automatic random_message(input int unsigned len, input bit may_cfg);
      int unsigned split;
      result_type none;
      none = '{crc: 32'd0, status: STATUS_OK};
      split = 0;
      if (may_cfg && $urandom_range(0, 1) == 0) begin
         random_cfg(len);
      end
      if (may_cfg && len >= 3 && $urandom_range(0, 9) == 0) begin
         split = $urandom_range(1, len - 1);
      end
      for (int unsigned i = 0; i < len; i++) begin
         if (split != 0 && i == split) begin
            // swap crc width part way through the message
            set_cfg(random_kind(), shadow_cfg.offset, shadow_cfg.length);
         end
         send_byte(8'($urandom_range(0, 255)), i == len - 1, 1'b0, none);
      end
   endtask

   // result side: checks each word and stalls on a pattern of its own
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (crc_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected word crc=%h status=%0d", $time, rsp_tdata, rsp_tuser);
            end else begin
               want = crc_expected.pop_front();
               results_checked++;
               if (rsp_tdata !== want.crc || rsp_tuser !== want.status) begin
                  errors++;
                  $display("%0t: mismatch expected crc=%h status=%0d, actual crc=%h status=%0d",
                           $time, want.crc, want.status, rsp_tdata, rsp_tuser);
               end
            end
         end
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_CHOPPY: rsp_tready <= ($urandom_range(0, 1) == 0);
               default:   rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin
      shadow_cfg = '{kind: KIND_CRC8, offset: 16'd0, length: 16'd0};
      run_acc = CRC_INIT;
      run_pos = 0;
      dir_rows = '{
         '{1'b0, KIND_CRC8,  16'd0,     16'd0,     1,     FILL_ZERO,   1'b1, 1'b1,
           STATUS_OK, 32'h0000_00FF},
         '{1'b1, KIND_CRC8,  16'd0,     16'd9,     9,     FILL_DIGITS, 1'b1, 1'b1,
           STATUS_OK, 32'h0000_00B4},
         '{1'b1, KIND_CRC16, 16'd0,     16'd9,     9,     FILL_DIGITS, 1'b1, 1'b1,
           STATUS_OK, 32'h0000_29B1},
         '{1'b1, KIND_CRC32, 16'd0,     16'd9,     9,     FILL_DIGITS, 1'b1, 1'b1,
           STATUS_OK, 32'h0376_E6E7},
         '{1'b1, KIND_CRC32, 16'd0,     16'd0,     1,     FILL_ONES,   1'b1, 1'b1,
           STATUS_OK, 32'hFFFF_FFFF},
         '{1'b1, KIND_CRC16, 16'd0,     16'd0,     1,     FILL_ONES,   1'b1, 1'b1,
           STATUS_OK, 32'h0000_FFFF},
         '{1'b1, KIND_NONE,  16'd0,     16'd4,     4,     FILL_RANDOM, 1'b1, 1'b1,
           STATUS_KIND, 32'd0},
         '{1'b1, KIND_NONE,  16'd0,     16'd5,     4,     FILL_RANDOM, 1'b1, 1'b1,
           STATUS_WINDOW, 32'd0},
         '{1'b1, KIND_CRC8,  16'd3,     16'd2,     4,     FILL_RANDOM, 1'b1, 1'b1,
           STATUS_WINDOW, 32'd0},
         '{1'b1, KIND_CRC32, 16'hFFFF,  16'hFFFF,  3,     FILL_RANDOM, 1'b1, 1'b1,
           STATUS_WINDOW, 32'd0},
         '{1'b1, KIND_CRC16, 16'd1,     16'd3,     4,     FILL_ONES,   1'b1, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC32, 16'd2,     16'd2,     6,     FILL_RANDOM, 1'b1, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC8,  16'd0,     16'd3,     2,     FILL_RANDOM, 1'b0, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC32, 16'd0,     16'd3,     3,     FILL_RANDOM, 1'b1, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC16, 16'd0,     16'd2,     2,     FILL_RANDOM, 1'b0, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_NONE,  16'd0,     16'd2,     1,     FILL_RANDOM, 1'b0, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC16, 16'd0,     16'd2,     1,     FILL_ZERO,   1'b1, 1'b0,
           STATUS_OK, 32'd0},
         '{1'b1, KIND_CRC8,  16'd0,     16'd0,     1,     FILL_ZERO,   1'b1, 1'b1,
           STATUS_OK, 32'h0000_00FF},
         '{1'b1, KIND_CRC32, 16'd0,     16'd1,     1,     FILL_ONES,   1'b1, 1'b0,
           STATUS_OK, 32'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned r = 0; r < DIR_ROWS; r++) begin
         run_row(dir_rows[r]);
      end

      // hold the result side off while one-byte messages pile up behind it
      set_cfg(KIND_CRC32, 16'd0, 16'd1);
      hold_request = 1'b1;
      for (int unsigned m = 0; m < PRESSURE_MSGS; m++) begin
         random_message(1, 1'b0);
      end

      while (bytes_sent < RANDOM_BYTES) begin
         random_message(($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
                                                      : $urandom_range(1, 12), 1'b1);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("tb summary: %0d bytes, %0d messages, %0d words checked, %0d register writes",
               bytes_sent, msgs_sent, results_checked, cfg_writes);
      $display("tb summary: all crc widths, window faults, unsupported kind, mid-message swaps");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
src/mwcrc_pkg.sv
src/mwcrc_update.sv
src/multi_width_crc_window_engine.sv
dv/tb_multi_width_crc_window_engine.sv
